### src/qau_pkg.sv
// Shared types, constants and arithmetic helpers for the quaternion arithmetic unit.
package qau_pkg;

  // Fixed-point format and derived widths.
  localparam int FRAC_BITS  = 16;
  localparam int COMP_W     = 32;
  localparam int PROD_W     = 2 * COMP_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int QUOT_W     = COMP_W + FRAC_BITS;
  localparam int LEN_W      = COMP_W + 1;
  localparam int SQRT_STEPS = COMP_W;
  localparam int CNT_W      = $clog2(QUOT_W);

  // Queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [3:0] kind_t;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  // Operation codes.
  localparam kind_t KIND_MUL       = 4'd0;
  localparam kind_t KIND_ADD       = 4'd1;
  localparam kind_t KIND_SUB       = 4'd2;
  localparam kind_t KIND_SCALE     = 4'd3;
  localparam kind_t KIND_DIVIDE    = 4'd4;
  localparam kind_t KIND_DOT       = 4'd5;
  localparam kind_t KIND_LENSQ     = 4'd6;
  localparam kind_t KIND_LENGTH    = 4'd7;
  localparam kind_t KIND_NORM_ID   = 4'd8;
  localparam kind_t KIND_NORM_ZERO = 4'd9;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAT     = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;

  // Operation class decided by the front part.
  typedef enum logic [3:0] {
    CLS_NONE,
    CLS_MUL,
    CLS_ADD,
    CLS_SUB,
    CLS_SCALE,
    CLS_DOT,
    CLS_DIVZERO,
    CLS_UNIT,
    CLS_DIV,
    CLS_LENGTH,
    CLS_NORM
  } cls_t;

  // Iterative engine states.
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SQRT,
    ENG_DIV,
    ENG_DONE
  } eng_state_t;

  typedef struct packed {
    kind_t kind;
    comp_t a_w;
    comp_t a_x;
    comp_t a_y;
    comp_t a_z;
    comp_t b_w;
    comp_t b_x;
    comp_t b_y;
    comp_t b_z;
  } in_item_t;

  typedef struct packed {
    comp_t      r_w;
    comp_t      r_x;
    comp_t      r_y;
    comp_t      r_z;
    logic [1:0] status;
  } out_item_t;

  // Classified item held in the queue; index 0 is the scalar part.
  typedef struct packed {
    cls_t        cls;
    comp_t [3:0] a;
    comp_t [3:0] b;
  } op_t;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_BITS - 1);

  // Round a raw product to the fixed-point grid, with halves rounded up (toward plus infinity).
  function automatic logic signed [ACC_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
    logic signed [ACC_W-1:0] wide;
    wide = ACC_W'(p);
    return (wide + HALF_LSB) >>> FRAC_BITS;
  endfunction

  // True when a wide value does not fit in one component.
  function automatic logic over_range(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-COMP_W:0] top;
    top = v[ACC_W-1:COMP_W-1];
    return !((&top) || (~|top));
  endfunction

  // Clamp a wide value to one component.
  function automatic comp_t sat_comp(input logic signed [ACC_W-1:0] v);
    comp_t res;
    if (over_range(v)) begin
      res = v[ACC_W-1] ? COMP_MIN : COMP_MAX;
    end else begin
      res = v[COMP_W-1:0];
    end
    return res;
  endfunction

endpackage

### src/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit: top level joining the front part, the queue and the back part.
//
// Takes one item per cycle unless the queue is full, and returns one result item for each, in
// order. Product, add, subtract, scale, dot and squared-length items, and divides by zero and
// normalizes of a zero quaternion, pass the back part at one item per cycle while the output
// is not stalled, through the queue, the product register and the output register. Divide holds
// the back part for 48 restoring divide steps in four parallel lanes, length for 32 square root
// steps, and normalize for the square root followed by the divide; the bit-per-cycle square root
// and divider engine serves one item at a time. A two-item queue keeps input accepting while the
// engine is busy, until it is full. Results saturate to the 32-bit range with status 1; divide by
// zero gives status 2 and a zero result.
module quaternion_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  qau_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qau_pkg::out_item_t out_data
);
  import qau_pkg::*;

  op_t  front_op;
  op_t  queue_op;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;

  assign in_stall = queue_full;

  qau_front u_front (
    .item (in_data),
    .op   (front_op)
  );

  qau_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (in_valid),
    .push_op (front_op),
    .full    (queue_full),
    .pop     (queue_pop),
    .pop_op  (queue_op),
    .empty   (queue_empty)
  );

  qau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!queue_empty),
    .q_op      (queue_op),
    .q_pop     (queue_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### src/qau_front.sv
// Front part: decodes the operation code and prepares the operands of one item.
module qau_front (
  input  qau_pkg::in_item_t item,
  output qau_pkg::op_t      op
);
  import qau_pkg::*;

  logic uses_square;
  logic a_zero;
  logic b_w_zero;
  cls_t cls;

  // Operations on the length of a use a as both factors.
  always_comb begin
    uses_square = (item.kind == KIND_LENSQ) || (item.kind == KIND_LENGTH) ||
                  (item.kind == KIND_NORM_ID) || (item.kind == KIND_NORM_ZERO);
    a_zero      = (item.a_w == '0) && (item.a_x == '0) && (item.a_y == '0) &&
                  (item.a_z == '0);
    b_w_zero    = (item.b_w == '0);

    op.cls  = cls;
    op.a[0] = item.a_w;
    op.a[1] = item.a_x;
    op.a[2] = item.a_y;
    op.a[3] = item.a_z;
    op.b[0] = uses_square ? item.a_w : item.b_w;
    op.b[1] = uses_square ? item.a_x : item.b_x;
    op.b[2] = uses_square ? item.a_y : item.b_y;
    op.b[3] = uses_square ? item.a_z : item.b_z;
  end

  // Classify; trivial divide and normalize cases are settled here.
  always_comb begin
    unique case (item.kind) inside
      KIND_MUL:              cls = CLS_MUL;
      KIND_ADD:              cls = CLS_ADD;
      KIND_SUB:              cls = CLS_SUB;
      KIND_SCALE:            cls = CLS_SCALE;
      KIND_DIVIDE:           cls = b_w_zero ? CLS_DIVZERO : CLS_DIV;
      KIND_DOT, KIND_LENSQ:  cls = CLS_DOT;
      KIND_LENGTH:           cls = CLS_LENGTH;
      KIND_NORM_ID:          cls = a_zero ? CLS_UNIT : CLS_NORM;
      KIND_NORM_ZERO:        cls = a_zero ? CLS_NONE : CLS_NORM;
      default:               cls = CLS_NONE;
    endcase
  end

endmodule

### src/qau_fifo.sv
// Short queue of classified items between the front and back parts.
module qau_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  qau_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output qau_pkg::op_t pop_op,
  output logic         empty
);
  import qau_pkg::*;

  op_t               entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push_ok;
  logic              pop_ok;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign pop_op  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

### src/qau_back.sv
// Back part: product stage, square root and divide engine, and output register.
module qau_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  qau_pkg::op_t       q_op,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output qau_pkg::out_item_t out_data
);
  import qau_pkg::*;

  // Product stage.
  logic                     a_valid;
  op_t                      a_op;
  logic signed [PROD_W-1:0] prod [4][4];
  logic                     a_slow;
  logic                     a_done;
  logic                     out_free;
  logic                     a_adv;

  // Engine.
  eng_state_t               state;
  eng_state_t               state_next;
  logic [CNT_W-1:0]         cnt;
  logic [PROD_W-1:0]        sq_x;
  logic [PROD_W-1:0]        sq_res;
  logic [PROD_W-1:0]        sq_bit;
  logic                     sq_carry;
  logic [PROD_W-1:0]        sq_x_next;
  logic [PROD_W-1:0]        sq_res_next;
  logic [PROD_W-1:0]        sq_trial;
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         len_next;
  logic [PROD_W:0]          sum_sq;
  logic [LEN_W-1:0]         div_d;
  logic [LEN_W-1:0]         rem  [4];
  logic [QUOT_W-1:0]        quot [4];
  logic                     neg  [4];
  logic [COMP_W-1:0]        mag_a [4];
  logic [COMP_W-1:0]        mag_bw;

  // Engine control.
  logic start_sqrt;
  logic start_div;
  logic sqrt_step;
  logic sqrt_last;
  logic div_from_sqrt;
  logic div_step;
  logic div_last;

  // Result assembly.
  logic signed [ACC_W-1:0]  rnd [4][4];
  logic signed [ACC_W-1:0]  acc [4];
  logic signed [ACC_W-1:0]  lane_res [4];
  logic                     any_sat;
  logic                     div_zero;
  out_item_t                res;

  // Stage handshake.
  always_comb begin
    a_slow   = a_op.cls inside {CLS_DIV, CLS_LENGTH, CLS_NORM};
    a_done   = !a_slow || (state == ENG_DONE);
    out_free = !out_valid || !out_stall;
    a_adv    = a_valid && a_done && out_free;
    q_pop    = q_valid && (!a_valid || a_adv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (q_pop) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  // Sixteen parallel products of the operand components.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_op <= q_op;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[i][j] <= PROD_W'($signed(q_op.a[i])) * PROD_W'($signed(q_op.b[j]));
        end
      end
    end
  end

  // Magnitudes, sum of squares and one square root step.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_a[i] = a_op.a[i][COMP_W-1] ? COMP_W'(-a_op.a[i]) : COMP_W'(a_op.a[i]);
    end
    mag_bw = a_op.b[0][COMP_W-1] ? COMP_W'(-a_op.b[0]) : COMP_W'(a_op.b[0]);
    sum_sq = (PROD_W+1)'($unsigned(prod[0][0])) + (PROD_W+1)'($unsigned(prod[1][1])) +
             (PROD_W+1)'($unsigned(prod[2][2])) + (PROD_W+1)'($unsigned(prod[3][3]));
    sq_trial = sq_res + sq_bit;
    if (sq_x >= sq_trial) begin
      sq_x_next   = sq_x - sq_trial;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_x_next   = sq_x;
      sq_res_next = sq_res >> 1;
    end
    len_next = sq_carry ? (LEN_W'(1) << COMP_W) : sq_res_next[LEN_W-1:0];
  end

  // Engine next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: begin
        if (a_valid && a_slow) begin
          state_next = (a_op.cls == CLS_DIV) ? ENG_DIV : ENG_SQRT;
        end
      end
      ENG_SQRT: begin
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = (a_op.cls == CLS_LENGTH) ? ENG_DONE : ENG_DIV;
        end
      end
      ENG_DIV: begin
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          state_next = ENG_DONE;
        end
      end
      ENG_DONE: begin
        if (a_adv) begin
          state_next = ENG_IDLE;
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  // Engine control outputs.
  always_comb begin
    start_sqrt    = (state == ENG_IDLE) && a_valid && a_slow && (a_op.cls != CLS_DIV);
    start_div     = (state == ENG_IDLE) && a_valid && (a_op.cls == CLS_DIV);
    sqrt_step     = (state == ENG_SQRT);
    sqrt_last     = sqrt_step && (cnt == CNT_W'(SQRT_STEPS - 1));
    div_from_sqrt = sqrt_last && (a_op.cls == CLS_NORM);
    div_step      = (state == ENG_DIV);
    div_last      = div_step && (cnt == CNT_W'(QUOT_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Engine datapath: bitwise square root and four restoring divider lanes; for normalize the divide follows the root.
  always_ff @(posedge clk) begin
    if (start_sqrt || start_div || div_from_sqrt) begin
      cnt <= '0;
    end else if (sqrt_step || (div_step && !div_last)) begin
      cnt <= cnt + 1'b1;
    end

    if (start_sqrt) begin
      sq_x     <= sum_sq[PROD_W-1:0];
      sq_carry <= sum_sq[PROD_W];
      sq_res   <= '0;
      sq_bit   <= PROD_W'(1) << (PROD_W - 2);
    end else if (sqrt_step) begin
      sq_x   <= sq_x_next;
      sq_res <= sq_res_next;
      sq_bit <= sq_bit >> 2;
    end

    if (sqrt_last) begin
      len <= len_next;
    end

    if (start_div || div_from_sqrt) begin
      div_d <= start_div ? {1'b0, mag_bw} : len_next;
      for (int i = 0; i < 4; i++) begin
        rem[i]  <= '0;
        quot[i] <= {mag_a[i], {FRAC_BITS{1'b0}}};
        neg[i]  <= a_op.a[i][COMP_W-1] ^ (start_div && a_op.b[0][COMP_W-1]);
      end
    end else if (div_step) begin
      for (int i = 0; i < 4; i++) begin
        if ({rem[i], quot[i][QUOT_W-1]} >= {1'b0, div_d}) begin
          rem[i] <= LEN_W'({rem[i], quot[i][QUOT_W-1]} - {1'b0, div_d});
          quot[i] <= {quot[i][QUOT_W-2:0], 1'b1};
        end else begin
          rem[i] <= LEN_W'({rem[i], quot[i][QUOT_W-1]});
          quot[i] <= {quot[i][QUOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Rounded products and signed quotients.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        rnd[i][j] = round_prod(prod[i][j]);
      end
      lane_res[i] = $signed({{(ACC_W-QUOT_W){1'b0}}, quot[i]});
      if (neg[i]) begin
        lane_res[i] = -lane_res[i];
      end
    end
  end

  // Result selection by operation class.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = '0;
    end
    div_zero = 1'b0;
    unique case (a_op.cls)
      CLS_MUL: begin
        acc[0] = rnd[0][0] - rnd[1][1] - rnd[2][2] - rnd[3][3];
        acc[1] = rnd[0][1] + rnd[1][0] + rnd[2][3] - rnd[3][2];
        acc[2] = rnd[0][2] + rnd[2][0] + rnd[3][1] - rnd[1][3];
        acc[3] = rnd[0][3] + rnd[3][0] + rnd[1][2] - rnd[2][1];
      end
      CLS_ADD: begin
        for (int i = 0; i < 4; i++) begin
          acc[i] = ACC_W'($signed(a_op.a[i])) + ACC_W'($signed(a_op.b[i]));
        end
      end
      CLS_SUB: begin
        for (int i = 0; i < 4; i++) begin
          acc[i] = ACC_W'($signed(a_op.a[i])) - ACC_W'($signed(a_op.b[i]));
        end
      end
      CLS_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          acc[i] = rnd[i][0];
        end
      end
      CLS_DOT: begin
        acc[0] = rnd[0][0] + rnd[1][1] + rnd[2][2] + rnd[3][3];
      end
      CLS_DIVZERO: begin
        div_zero = 1'b1;
      end
      CLS_UNIT: begin
        acc[0] = ACC_W'(1) <<< FRAC_BITS;
      end
      CLS_DIV, CLS_NORM: begin
        for (int i = 0; i < 4; i++) begin
          acc[i] = lane_res[i];
        end
      end
      CLS_LENGTH: begin
        acc[0] = $signed({{(ACC_W-LEN_W){1'b0}}, len});
      end
      default: begin
        div_zero = 1'b0;
      end
    endcase

    any_sat    = over_range(acc[0]) || over_range(acc[1]) ||
                 over_range(acc[2]) || over_range(acc[3]);
    res.r_w    = sat_comp(acc[0]);
    res.r_x    = sat_comp(acc[1]);
    res.r_y    = sat_comp(acc[2]);
    res.r_z    = sat_comp(acc[3]);
    res.status = div_zero ? ST_DIVZERO : (any_sat ? ST_SAT : ST_OK);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_data <= res;
    end
  end

endmodule

### src/qau_checker.sv
// Port-level checks for the quaternion arithmetic unit and their binding to the top level.
module qau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input qau_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input qau_pkg::out_item_t out_data
);
  import qau_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result item changed while stalled");

  // Saturation shows at least one component at a limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_SAT) |->
      (out_data.r_w == COMP_MAX) || (out_data.r_w == COMP_MIN) ||
      (out_data.r_x == COMP_MAX) || (out_data.r_x == COMP_MIN) ||
      (out_data.r_y == COMP_MAX) || (out_data.r_y == COMP_MIN) ||
      (out_data.r_z == COMP_MAX) || (out_data.r_z == COMP_MIN))
    else $error("saturation status without a clamped component");

  // Division by zero returns an all-zero quaternion.
  a_divzero_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_DIVZERO) |->
      (out_data.r_w == '0) && (out_data.r_x == '0) &&
      (out_data.r_y == '0) && (out_data.r_z == '0))
    else $error("division by zero with a nonzero result");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item offered after reset");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);
